[rtl/irdla_pkg.sv]
// shared types, constants and helpers for the infrared distance linearizer
// no dependencies
`default_nettype none

package irdla_pkg;

  localparam int unsigned AVG_DEPTH = 8;
  localparam int unsigned AVG_SHIFT = $clog2(AVG_DEPTH);
  localparam int unsigned PTR_W     = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
  localparam int unsigned DIST_W    = 24;
  localparam int unsigned SUM_W     = DIST_W + AVG_SHIFT;

  localparam int unsigned NUM_W = 32;
  localparam int unsigned DEN_W = 21;
  localparam int unsigned DVS_W = DEN_W - 1;
  localparam int unsigned QUO_W = NUM_W + 1;
  localparam int unsigned CNT_W = $clog2(NUM_W);

  localparam logic [NUM_W-1:0] NEAR_NUM = 32'd3094609920;
  localparam logic [NUM_W-1:0] FAR_NUM  = 32'd3233284096;
  localparam logic signed [DEN_W-1:0] NEAR_OFF = 21'sd38925;
  localparam logic signed [DEN_W-1:0] FAR_OFF  = 21'sd27405;
  localparam logic signed [QUO_W:0] NEAR_SUB = 34'sd512;
  localparam logic signed [QUO_W:0] FAR_SUB  = 34'sd640;

  localparam logic [7:0] SWITCH_RST = 8'd90;
  localparam logic [7:0] MAXV_RST   = 8'd160;

  localparam logic REG_SWITCH = 1'b0;
  localparam logic REG_MAXV   = 1'b1;

  localparam logic signed [QUO_W:0] SAT_MAX = 34'sd8388607;
  localparam logic signed [QUO_W:0] SAT_MIN = -34'sd8388608;

  typedef struct packed {
    logic                    start;
    logic [NUM_W-1:0]        num;
    logic signed [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [QUO_W-1:0] quo;
  } div_rsp_t;

  function automatic logic signed [DIST_W-1:0] sat24(input logic signed [QUO_W:0] v);
    logic signed [DIST_W-1:0] r;
    if (v > SAT_MAX) begin
      r = SAT_MAX[DIST_W-1:0];
    end else if (v < SAT_MIN) begin
      r = SAT_MIN[DIST_W-1:0];
    end else begin
      r = v[DIST_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/ir_distance_linearize_average.sv]
// infrared range linearizer with moving average: each transaction runs the near
// law and, when its distance lies above the switch point, the far law as well, both
// on the shared one-bit-per-cycle divider; a new transaction is taken only when idle.
// a waiting result lets the next transaction in but holds its end until taken.
// reset clears history, sum and registers at once, no clearing pass.
// depends on irdla_pkg and irdla_div
`default_nettype none

module ir_distance_linearize_average (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output      logic        in_ready_o,
  input  wire logic [9:0]  adc_reading_i,
  output      logic        out_valid_o,
  input  wire logic        out_ready_i,
  output      logic [15:0] distance_q8_o,
  output      logic        valid_res_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output      logic [31:0] prdata,
  output      logic        pready
);
  import irdla_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_NEAR,
    S_FAR,
    S_UPD,
    S_OUT
  } state_e;

  state_e                   state_q;
  logic                     start_q;
  logic                     far_q;
  logic [9:0]               x_q;
  logic signed [DIST_W-1:0] d_q;
  logic [7:0]               switch_q;
  logic [7:0]               maxv_q;
  logic signed [DIST_W-1:0] hist_q [AVG_DEPTH];
  logic signed [SUM_W-1:0]  sum_q;
  logic [PTR_W-1:0]         pos_q;
  logic                     out_valid_q;
  logic [15:0]              dist_q;
  logic                     res_ok_q;

  div_req_t                 div_req;
  div_rsp_t                 div_rsp;
  logic signed [DEN_W-1:0]  x_scaled;
  logic signed [DIST_W-1:0] d_law;
  logic signed [DIST_W:0]   switch_q8;
  logic signed [SUM_W-1:0]  biased;
  logic signed [SUM_W-1:0]  avg;
  logic signed [SUM_W-1:0]  maxv_q8;
  logic                     ok;
  logic                     cfg_wr;

  irdla_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign x_scaled      = $signed({1'b0, x_q, 10'b0});
  assign div_req.start = start_q;
  assign div_req.num   = far_q ? FAR_NUM : NEAR_NUM;
  assign div_req.den   = x_scaled - (far_q ? FAR_OFF : NEAR_OFF);

  assign d_law     = sat24({div_rsp.quo[QUO_W-1], div_rsp.quo} - (far_q ? FAR_SUB : NEAR_SUB));
  assign switch_q8 = $signed({1'b0, switch_q, 8'b0});

  assign biased  = sum_q + (sum_q[SUM_W-1] ? SUM_W'(AVG_DEPTH - 1) : '0);
  assign avg     = biased >>> AVG_SHIFT;
  assign maxv_q8 = $signed({{(SUM_W-16){1'b0}}, maxv_q, 8'b0});
  assign ok      = (avg > 0) && (avg <= maxv_q8);

  assign in_ready_o    = (state_q == S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign distance_q8_o = dist_q;
  assign valid_res_o   = res_ok_q;

  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;
  assign prdata = {24'b0, (paddr[2] == REG_MAXV) ? maxv_q : switch_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      switch_q <= SWITCH_RST;
      maxv_q   <= MAXV_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_SWITCH: switch_q <= pwdata[7:0];
        REG_MAXV:   maxv_q   <= pwdata[7:0];
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      start_q     <= 1'b0;
      far_q       <= 1'b0;
      sum_q       <= '0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
      res_ok_q    <= 1'b0;
      for (int i = 0; i < AVG_DEPTH; i++) begin
        hist_q[i] <= '0;
      end
    end else begin
      start_q <= 1'b0;
      if (out_valid_q && out_ready_i && state_q != S_OUT) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            far_q   <= 1'b0;
            start_q <= 1'b1;
            state_q <= S_NEAR;
          end
        end
        S_NEAR: begin
          if (div_rsp.done) begin
            if ($signed({d_law[DIST_W-1], d_law}) > switch_q8) begin
              far_q   <= 1'b1;
              start_q <= 1'b1;
              state_q <= S_FAR;
            end else begin
              state_q <= S_UPD;
            end
          end
        end
        S_FAR: begin
          if (div_rsp.done) begin
            state_q <= S_UPD;
          end
        end
        S_UPD: begin
          sum_q         <= sum_q - SUM_W'(hist_q[pos_q]) + SUM_W'(d_q);
          hist_q[pos_q] <= d_q;
          pos_q         <= (pos_q == PTR_W'(AVG_DEPTH - 1)) ? '0 : pos_q + 1'b1;
          state_q       <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            res_ok_q    <= ok;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      x_q <= adc_reading_i;
    end
    if ((state_q == S_NEAR || state_q == S_FAR) && div_rsp.done) begin
      d_q <= d_law;
    end
    if (state_q == S_OUT && (!out_valid_q || out_ready_i)) begin
      dist_q <= ok ? avg[15:0] : 16'd0;
    end
  end

endmodule

`default_nettype wire

[rtl/irdla_div.sv]
// iterative unsigned-by-signed divider, one quotient bit per cycle, truncating
// depends on irdla_pkg
`default_nettype none

module irdla_div (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire irdla_pkg::div_req_t req_i,
  output      irdla_pkg::div_rsp_t rsp_o
);
  import irdla_pkg::*;

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DVS_W-1:0] rem_q;
  logic [NUM_W-1:0] quo_q;
  logic [DVS_W-1:0] dvs_q;
  logic             neg_q;
  logic             zero_q;

  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             fits;
  logic [DEN_W-1:0] den_abs;

  assign trial   = {rem_q, quo_q[NUM_W-1]};
  assign diff    = trial - {1'b0, dvs_q};
  assign fits    = (trial >= {1'b0, dvs_q});
  assign den_abs = req_i.den[DEN_W-1] ? (~req_i.den + 1'b1) : req_i.den;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(NUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q  <= '0;
      quo_q  <= req_i.num;
      dvs_q  <= den_abs[DVS_W-1:0];
      neg_q  <= req_i.den[DEN_W-1];
      zero_q <= (req_i.den == '0);
    end else if (busy_q) begin
      rem_q <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      quo_q <= {quo_q[NUM_W-2:0], fits};
    end
  end

  always_comb begin
    rsp_o.done = done_q;
    if (zero_q) begin
      rsp_o.quo = '0;
    end else if (neg_q) begin
      rsp_o.quo = -$signed({1'b0, quo_q});
    end else begin
      rsp_o.quo = $signed({1'b0, quo_q});
    end
  end

endmodule

`default_nettype wire

[bench/ir_distance_linearize_average_tb.sv]
// testbench for ir_distance_linearize_average: directed and random adc samples,
// register writes between phases, results checked against an inline range predictor
// depends on irdla_pkg and the rtl of ir_distance_linearize_average
`default_nettype none

module ir_distance_linearize_average_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import irdla_pkg::*;

  typedef struct {
    logic [15:0] distance;
    logic        vres;
  } range_result_t;

  class range_scoreboard;
    localparam longint NEAR_K   = 64'sd11805 * 64'sd262144;
    localparam longint FAR_K    = 64'sd12334 * 64'sd262144;
    localparam longint NEAR_Q10 = 64'sd38925;
    localparam longint FAR_Q10  = 64'sd27405;
    localparam longint NEAR_OFS = 64'sd512;
    localparam longint FAR_OFS  = 64'sd640;
    localparam longint DIST_MAX = 64'sd8388607;
    localparam longint DIST_MIN = -64'sd8388608;

    longint        hist[AVG_DEPTH];
    longint        hist_sum;
    int unsigned   wr_pos;
    logic [7:0]    switch_cm;
    logic [7:0]    max_valid_cm;
    range_result_t pending_q[$];
    int unsigned   errors;

    function new();
      foreach (hist[i]) hist[i] = 0;
      hist_sum     = 0;
      wr_pos       = 0;
      switch_cm    = 8'd90;
      max_valid_cm = 8'd160;
      errors       = 0;
    endfunction

    function void report(string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      errors++;
    endfunction

    function void set_reg(logic idx, logic [31:0] value);
      if (idx == REG_SWITCH) begin
        switch_cm = value[7:0];
      end else begin
        max_valid_cm = value[7:0];
      end
    endfunction

    function logic [7:0] reg_value(logic idx);
      return (idx == REG_SWITCH) ? switch_cm : max_valid_cm;
    endfunction

    function longint inverse_dist(longint x, longint k, longint ofs_q10, longint sub_q8);
      longint den;
      longint q;
      den = x * 1024 - ofs_q10;
      q   = (den == 0) ? 0 : k / den;
      q   = q - sub_q8;
      if (q > DIST_MAX) q = DIST_MAX;
      if (q < DIST_MIN) q = DIST_MIN;
      return q;
    endfunction

    function void note_input(logic [9:0] adc);
      longint        x;
      longint        d;
      longint        avg;
      logic          ok;
      range_result_t r;
      x = longint'(adc);
      d = inverse_dist(x, NEAR_K, NEAR_Q10, NEAR_OFS);
      if (d > longint'(switch_cm) * 256) d = inverse_dist(x, FAR_K, FAR_Q10, FAR_OFS);
      hist_sum     = hist_sum - hist[wr_pos] + d;
      hist[wr_pos] = d;
      wr_pos       = (wr_pos + 1 >= AVG_DEPTH) ? 0 : wr_pos + 1;
      avg          = hist_sum / longint'(AVG_DEPTH);
      ok           = (avg > 0) && (avg <= longint'(max_valid_cm) * 256);
      r.distance   = ok ? avg[15:0] : 16'd0;
      r.vres       = ok;
      pending_q.push_back(r);
    endfunction

    function void check_result(logic [15:0] distance, logic vres);
      range_result_t e;
      if (pending_q.size() == 0) begin
        report($sformatf("result with none pending: distance %0d valid %0b", distance, vres));
        return;
      end
      e = pending_q.pop_front();
      if (distance !== e.distance) begin
        report($sformatf("distance_q8 got %0d want %0d", distance, e.distance));
      end
      if (vres !== e.vres) report($sformatf("valid_res got %0b want %0b", vres, e.vres));
    endfunction

    function int pending();
      return pending_q.size();
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [9:0]  adc_reading_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [15:0] distance_q8_o;
  logic        valid_res_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  range_scoreboard sb;
  int unsigned     send_idle_pct;
  int unsigned     recv_idle_pct;
  int unsigned     send_burst;
  int unsigned     recv_burst;

  ir_distance_linearize_average dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .adc_reading_i (adc_reading_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .distance_q8_o (distance_q8_o),
    .valid_res_o   (valid_res_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // receiver back-pressure
  always @(negedge clk_i) begin
    if (recv_burst > 0) begin
      recv_burst--;
      out_ready_i = 1'b1;
    end else if ($urandom_range(99) < 3) begin
      recv_burst  = $urandom_range(40, 10);
      out_ready_i = 1'b1;
    end else begin
      out_ready_i = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(distance_q8_o, valid_res_o);
  end

  task automatic send_sample(input logic [9:0] adc);
    if (send_burst > 0) begin
      send_burst--;
    end else if ($urandom_range(99) < 3) begin
      send_burst = $urandom_range(40, 10);
    end else begin
      while ($urandom_range(99) < send_idle_pct) begin
        in_valid_i    = 1'b0;
        adc_reading_i = 10'($urandom);
        @(negedge clk_i);
      end
    end
    in_valid_i    = 1'b1;
    adc_reading_i = adc;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_input(adc);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i = 1'b0;
    while (sb.pending() > 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic apb_access(input logic idx, input logic wr, input logic [31:0] wdata);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = {idx, 2'b00};
    pwdata  = wdata;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (wr) begin
      sb.set_reg(idx, wdata);
    end else if (prdata !== {24'd0, sb.reg_value(idx)}) begin
      sb.report($sformatf("register %0d read %0h want %0h", idx, prdata, sb.reg_value(idx)));
    end
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic set_ranges(input logic [7:0] sw, input logic [7:0] maxv);
    apb_access(REG_SWITCH, 1'b1, {8'($urandom_range(255)), 16'($urandom), sw});
    apb_access(REG_MAXV, 1'b1, {8'($urandom_range(255)), 16'($urandom), maxv});
    apb_access(REG_SWITCH, 1'b0, 32'd0);
    apb_access(REG_MAXV, 1'b0, 32'd0);
  endtask

  function automatic logic [9:0] pick_adc();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return 10'($urandom_range(650, 60));
    if (r < 85) return 10'($urandom_range(60, 20));
    return 10'($urandom_range(1023, 0));
  endfunction

  initial begin
    logic [9:0] warmup [13];
    logic [7:0] sw;
    logic [7:0] maxv;
    sb            = new();
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    adc_reading_i = 10'd0;
    out_ready_i   = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = 3'd0;
    pwdata        = 32'd0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_burst    = 0;
    recv_burst    = 0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // warm-up with reset ranges, offsets, extremes and the law switch point
    warmup = '{10'd0, 10'd1023, 10'd38, 10'd39, 10'd37, 10'd27, 10'd26,
               10'd512, 10'd166, 10'd167, 10'd165, 10'd100, 10'd300};
    foreach (warmup[i]) send_sample(warmup[i]);
    wait_drained();
    apb_access(REG_SWITCH, 1'b0, 32'd0);
    apb_access(REG_MAXV, 1'b0, 32'd0);
    set_ranges(8'd0, 8'd255);
    send_sample(10'd1023);
    send_sample(10'd200);
    send_sample(10'd40);
    send_sample(10'd28);
    wait_drained();
    set_ranges(8'd255, 8'd0);
    send_sample(10'd150);
    send_sample(10'd1023);
    send_sample(10'd682);
    send_sample(10'd341);
    wait_drained();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin sw = 8'd255; maxv = 8'd255; end
        1: begin sw = 8'd0;   maxv = 8'd0;   end
        3: begin sw = 8'd90;  maxv = 8'd160; end
        5: begin sw = 8'd255; maxv = 8'd160; end
        default: begin
          sw   = 8'($urandom);
          maxv = 8'($urandom);
        end
      endcase
      set_ranges(sw, maxv);
      send_idle_pct = (ph < 2) ? 35 : (ph < 4) ? 59 : 0;
      recv_idle_pct = (ph < 2) ? 59 : (ph < 4) ? 35 : 0;
      for (int n = 0; n < 165; n++) begin
        if (ph == 3 && n == 80) wait_drained();
        send_sample(pick_adc());
      end
      wait_drained();
    end

    send_idle_pct = 0;
    recv_idle_pct = 0;
    in_valid_i    = 1'b0;
    while (sb.pending() > 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
    if (sb.pending() != 0) sb.report($sformatf("%0d results never arrived", sb.pending()));
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("timeout with %0d results pending", sb.pending());
    $display("== FAIL ==");
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
rtl/irdla_pkg.sv
rtl/irdla_div.sv
rtl/ir_distance_linearize_average.sv
bench/ir_distance_linearize_average_tb.sv
